// File: rtl/bfl_pkg.sv
// Shared types, constants and constant tables for the binary focal loss accumulator.
// Depends on nothing; every other file in rtl/ imports it.
package bfl_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int PROB_BITS      = FRAC_BITS + 1;
	localparam int MEAN_BITS      = 8 + FRAC_BITS;
	localparam int SUM_BITS       = 48;
	localparam int COUNT_BITS_DEF = 24;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int LOG_BITS       = 21;  // -log2 magnitude, Q5.16
	localparam int LN_BITS        = 20;  // -ln magnitude, Q4.16
	localparam int TEXP_BITS      = 25;  // exponent of 2^-t, Q9.16
	localparam int TERM_BITS      = 21;

	localparam logic [PROB_BITS-1:0] ONE_Q   = PROB_BITS'(1) << FRAC_BITS;
	localparam logic [31:0]          LN2_Q32 = 32'd2977044472;

	// Register map (word index) and reset values
	localparam logic [1:0]  REG_GAMMA = 2'd0;
	localparam logic [1:0]  REG_ALPHA = 2'd1;
	localparam logic [1:0]  REG_EPS   = 2'd2;
	localparam logic [15:0] GAMMA_RST = 16'd8192;
	localparam logic [16:0] ALPHA_RST = 17'd16384;
	localparam logic [14:0] EPS_RST   = 15'd1;

	// Focusing exponents that take the exact multiply path, Q4.12
	localparam logic [15:0] GAMMA_ONE   = 16'd4096;
	localparam logic [15:0] GAMMA_TWO   = 16'd8192;
	localparam logic [15:0] GAMMA_THREE = 16'd12288;

	// One queued element after clamping and weighting
	typedef struct packed {
		logic [PROB_BITS-1:0] p;
		logic [PROB_BITS-1:0] q;
		logic [PROB_BITS-1:0] w1;
		logic [PROB_BITS-1:0] w2;
		logic                 last;
	} item_t;

	// Finished mean handed to the output register
	typedef struct packed {
		logic [MEAN_BITS-1:0] mean;
		logic                 sat;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG,
		ST_NL,
		ST_LN,
		ST_POW1,
		ST_POW2,
		ST_EXP,
		ST_PWSEL,
		ST_BMUL,
		ST_TMUL,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} bk_state_t;

	// Integer square root, one result bit per pass
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] rem;
		res = '0;
		bv  = 64'd1 << 62;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bv) begin
				rem = rem - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// Roots 2^-(2^-i) in Q0.32 for i = 1 .. FRAC_BITS, each taken from the one before
	function automatic logic [FRAC_BITS*32-1:0] build_roots();
		logic [63:0]             t;
		logic [FRAC_BITS*32-1:0] acc;
		t   = 64'd1 << 31;
		acc = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			t = isqrt64(t << 32);
			acc[i*32 +: 32] = t[31:0];
		end
		return acc;
	endfunction

	localparam logic [FRAC_BITS*32-1:0] ROOT_TAB = build_roots();

	function automatic logic [31:0] root_at(input logic [3:0] idx);
		return ROOT_TAB[{idx, 5'd0} +: 32];
	endfunction

	// Position of the leading one
	function automatic logic [4:0] lead_one(input logic [PROB_BITS-1:0] x);
		logic [4:0] k;
		k = '0;
		for (int i = 0; i < PROB_BITS; i++) begin
			if (x[i]) k = 5'(i);
		end
		return k;
	endfunction

endpackage

// File: rtl/bfl_front.sv
// Front end: clamps prediction, target and weight, then forms both class weights.
// Depends on bfl_pkg; feeds bfl_queue.
module bfl_front import bfl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [PROB_BITS-1:0]   pred_prob,
	input  logic [PROB_BITS-1:0]   target_label,
	input  logic                   is_last,
	input  logic [16:0]            alpha,
	input  logic [14:0]            eps,
	input  logic [QCOUNT_BITS-1:0] q_count,
	output logic                   q_push,
	output item_t                  q_item
);

	logic                 v_s1;
	logic [PROB_BITS-1:0] p_s1, y_s1, a_s1;
	logic                 last_s1;
	logic                 accept;
	logic [PROB_BITS-1:0] e, hi, pc, yc, ac, na, ny;
	logic [2*PROB_BITS-1:0] prod1, prod2;

	// Hold off while the queue plus the element in flight would fill it
	assign full   = ({1'b0, q_count} + (QCOUNT_BITS+1)'(v_s1)) >= (QCOUNT_BITS+1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	// Clamp; the margin register cannot exceed one half, so only zero needs fixing
	always_comb begin
		e  = (eps == '0) ? PROB_BITS'(1) : PROB_BITS'(eps);
		hi = ONE_Q - e;
		if (pred_prob < e) pc = e;
		else if (pred_prob > hi) pc = hi;
		else pc = pred_prob;
		yc = (target_label > ONE_Q) ? ONE_Q : target_label;
		ac = (alpha > ONE_Q) ? ONE_Q : alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1    <= pc;
			y_s1    <= yc;
			a_s1    <= ac;
			last_s1 <= is_last;
		end
	end

	// Weight both classes and push
	always_comb begin
		na    = ONE_Q - a_s1;
		ny    = ONE_Q - y_s1;
		prod1 = (2*PROB_BITS)'(a_s1) * (2*PROB_BITS)'(y_s1);
		prod2 = (2*PROB_BITS)'(na) * (2*PROB_BITS)'(ny);
		q_item.p    = p_s1;
		q_item.q    = ONE_Q - p_s1;
		q_item.w1   = prod1[2*FRAC_BITS:FRAC_BITS];
		q_item.w2   = prod2[2*FRAC_BITS:FRAC_BITS];
		q_item.last = last_s1;
	end

	assign q_push = v_s1;

endmodule

// File: rtl/bfl_queue.sv
// Short register queue between the front end and the sequencer.
// Depends on bfl_pkg for the element type and depth.
module bfl_queue import bfl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  item_t                  push_item,
	input  logic                   pop,
	output item_t                  head,
	output logic                   nempty,
	output logic [QCOUNT_BITS-1:0] count
);

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_q, rd_q;
	logic [QCOUNT_BITS-1:0] cnt_q;

	assign head   = mem_q[rd_q];
	assign nempty = (cnt_q != '0);
	assign count  = cnt_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_BITS'(1);
			if (pop)  rd_q <= rd_q + QPTR_BITS'(1);
			cnt_q <= cnt_q + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

// File: rtl/bfl_back.sv
// Sequencer: logarithms, powers and the focal term for each element, the running sum,
// and the final mean by long division. Depends on bfl_pkg; drains bfl_queue.
module bfl_back import bfl_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] gamma,
	input  item_t       head,
	input  logic        q_nempty,
	output logic        q_pop,
	input  logic        out_free,
	output logic        res_valid,
	output result_t     res
);

	localparam logic [5:0] LOG_END = 6'(FRAC_BITS - 1);
	localparam logic [5:0] DIV_END = 6'(SUM_BITS - 1);

	bk_state_t state_q, state_d;
	logic [5:0] cnt_q;

	item_t                 item_q;
	logic [30:0]           zp_q, zq_q;
	logic [FRAC_BITS-1:0]  fp_q, fq_q, frp_q, frq_q;
	logic [4:0]            kp_q, kq_q;
	logic [LOG_BITS-1:0]   nlp_q, nlq_q;
	logic [LN_BITS-1:0]    lnp_q, lnq_q;
	logic [8:0]            np_q, nq_q;
	logic [PROB_BITS-1:0]  sqp_q, sqq_q, cbp_q, cbq_q, pwp_q, pwq_q, b1_q, b2_q;
	logic [32:0]           rp_q, rq_q;
	logic [TERM_BITS-1:0]  t1_q, t2_q;
	logic [SUM_BITS-1:0]   sum_q, quot_q;
	logic [COUNT_BITS-1:0] count_q, rem_q;
	logic                  ovf_q;

	// Combinational datapath
	logic [4:0]               kp_ld, kq_ld;
	logic [61:0]              zzp, zzq;
	logic [31:0]              sp, sq;
	logic [LOG_BITS-1:0]      nlp_d, nlq_d;
	logic [52:0]              lnprod_p, lnprod_q;
	logic [36:0]              tprod_p, tprod_q;
	logic [TEXP_BITS-1:0]     tex_p, tex_q;
	logic [33:0]              sqprod_p, sqprod_q, cbprod_p, cbprod_q, bprod1, bprod2;
	logic [31:0]              root;
	logic [64:0]              rprod_p, rprod_q;
	logic [32:0]              rsh_p, rsh_q;
	logic [PROB_BITS-1:0]     gen_p, gen_q, pwp_d, pwq_d;
	logic [36:0]              tm1, tm2;
	logic [TERM_BITS:0]       term;
	logic [SUM_BITS:0]        sum_ext;
	logic [SUM_BITS-1:0]      sum_d;
	logic [COUNT_BITS:0]      rem_sh, rem_sub;
	logic                     ge;

	always_comb begin
		kp_ld    = lead_one(head.p);
		kq_ld    = lead_one(head.q);
		zzp      = 62'(zp_q) * 62'(zp_q);
		zzq      = 62'(zq_q) * 62'(zq_q);
		sp       = zzp[61:30];
		sq       = zzq[61:30];
		nlp_d    = (LOG_BITS'(5'(FRAC_BITS) - kp_q) << FRAC_BITS) - LOG_BITS'(fp_q);
		nlq_d    = (LOG_BITS'(5'(FRAC_BITS) - kq_q) << FRAC_BITS) - LOG_BITS'(fq_q);
		lnprod_p = 53'(nlp_q) * 53'(LN2_Q32);
		lnprod_q = 53'(nlq_q) * 53'(LN2_Q32);
		tprod_p  = 37'(gamma) * 37'(nlp_q);
		tprod_q  = 37'(gamma) * 37'(nlq_q);
		tex_p    = tprod_p[36:12];
		tex_q    = tprod_q[36:12];
		sqprod_p = 34'(item_q.p) * 34'(item_q.p);
		sqprod_q = 34'(item_q.q) * 34'(item_q.q);
		cbprod_p = 34'(sqp_q) * 34'(item_q.p);
		cbprod_q = 34'(sqq_q) * 34'(item_q.q);
		root     = root_at(cnt_q[3:0]);
		rprod_p  = 65'(rp_q) * 65'(root);
		rprod_q  = 65'(rq_q) * 65'(root);
		rsh_p    = rp_q >> np_q[5:0];
		rsh_q    = rq_q >> nq_q[5:0];
		gen_p    = (np_q >= 9'd33) ? '0 : rsh_p[32:16];
		gen_q    = (nq_q >= 9'd33) ? '0 : rsh_q[32:16];
		case (gamma)
			GAMMA_ONE: begin
				pwp_d = item_q.p;
				pwq_d = item_q.q;
			end
			GAMMA_TWO: begin
				pwp_d = sqp_q;
				pwq_d = sqq_q;
			end
			GAMMA_THREE: begin
				pwp_d = cbp_q;
				pwq_d = cbq_q;
			end
			default: begin
				pwp_d = gen_p;
				pwq_d = gen_q;
			end
		endcase
		bprod1  = 34'(item_q.w1) * 34'(pwq_q);
		bprod2  = 34'(item_q.w2) * 34'(pwp_q);
		tm1     = 37'(b1_q) * 37'(lnp_q);
		tm2     = 37'(b2_q) * 37'(lnq_q);
		term    = (TERM_BITS+1)'(t1_q) + (TERM_BITS+1)'(t2_q);
		sum_ext = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(term);
		sum_d   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
		rem_sh  = {rem_q, quot_q[SUM_BITS-1]};
		rem_sub = rem_sh - {1'b0, count_q};
		ge      = rem_sh >= {1'b0, count_q};
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_nempty) begin
					q_pop   = 1'b1;
					state_d = ST_LOG;
				end
			end
			ST_LOG:   if (cnt_q == LOG_END) state_d = ST_NL;
			ST_NL:    state_d = ST_LN;
			ST_LN:    state_d = ST_POW1;
			ST_POW1:  state_d = ST_POW2;
			ST_POW2:  state_d = ST_EXP;
			ST_EXP:   if (cnt_q == LOG_END) state_d = ST_PWSEL;
			ST_PWSEL: state_d = ST_BMUL;
			ST_BMUL:  state_d = ST_TMUL;
			ST_TMUL:  state_d = ST_ACC;
			ST_ACC:   state_d = item_q.last ? ST_DIV : ST_IDLE;
			ST_DIV:   if (cnt_q == DIV_END) state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	assign res.mean = (quot_q[SUM_BITS-1:MEAN_BITS] != '0) ? '1 : quot_q[MEAN_BITS-1:0];
	assign res.sat  = (quot_q[SUM_BITS-1:MEAN_BITS] != '0) || ovf_q;

	// Step counter and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOG, ST_EXP, ST_DIV: cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : '0;
				default:                cnt_q <= '0;
			endcase
			if (state_q == ST_ACC) begin
				sum_q <= sum_d;
				if (sum_ext[SUM_BITS]) ovf_q <= 1'b1;
				if (count_q == '1) ovf_q <= 1'b1;
				else count_q <= count_q + COUNT_BITS'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				sum_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= head;
				kp_q   <= kp_ld;
				kq_q   <= kq_ld;
				zp_q   <= 31'(head.p) << (5'd30 - kp_ld);
				zq_q   <= 31'(head.q) << (5'd30 - kq_ld);
				fp_q   <= '0;
				fq_q   <= '0;
			end
			ST_LOG: begin
				zp_q <= sp[31] ? sp[31:1] : sp[30:0];
				zq_q <= sq[31] ? sq[31:1] : sq[30:0];
				fp_q <= {fp_q[FRAC_BITS-2:0], sp[31]};
				fq_q <= {fq_q[FRAC_BITS-2:0], sq[31]};
			end
			ST_NL: begin
				nlp_q <= nlp_d;
				nlq_q <= nlq_d;
			end
			ST_LN: begin
				lnp_q <= lnprod_p[51:32];
				lnq_q <= lnprod_q[51:32];
				np_q  <= tex_p[TEXP_BITS-1:FRAC_BITS];
				nq_q  <= tex_q[TEXP_BITS-1:FRAC_BITS];
				frp_q <= tex_p[FRAC_BITS-1:0];
				frq_q <= tex_q[FRAC_BITS-1:0];
			end
			ST_POW1: begin
				sqp_q <= sqprod_p[32:16];
				sqq_q <= sqprod_q[32:16];
				rp_q  <= 33'd1 << 32;
				rq_q  <= 33'd1 << 32;
			end
			ST_POW2: begin
				cbp_q <= cbprod_p[32:16];
				cbq_q <= cbprod_q[32:16];
			end
			ST_EXP: begin
				if (frp_q[FRAC_BITS-1]) rp_q <= rprod_p[64:32];
				if (frq_q[FRAC_BITS-1]) rq_q <= rprod_q[64:32];
				frp_q <= frp_q << 1;
				frq_q <= frq_q << 1;
			end
			ST_PWSEL: begin
				pwp_q <= pwp_d;
				pwq_q <= pwq_d;
			end
			ST_BMUL: begin
				b1_q <= bprod1[32:16];
				b2_q <= bprod2[32:16];
			end
			ST_TMUL: begin
				t1_q <= tm1[36:16];
				t2_q <= tm2[36:16];
			end
			ST_ACC: begin
				quot_q <= sum_d;
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
				quot_q <= {quot_q[SUM_BITS-2:0], ge};
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/binary_focal_loss_accumulator.sv
// Top level of the binary focal loss accumulator: register port, front end, queue,
// sequencer and output register. Depends on bfl_pkg, bfl_front, bfl_queue, bfl_back.
//
//  channel   handshake            payload
//  input     push / full          pred_prob, target_label, is_last
//  result    empty / pop          mean_loss, saturated
//  config    psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// For each element the sequencer runs two 16-step log squarings, a 16-step root
// product for the general power and a few single multiplies. An element marked last
// adds a long division of the sum by the count and the hand-over of the mean.
// The front end takes a new element each cycle until the 4-entry queue fills.
// Reset clears the running sum, count and all control; the registers take their defaults.
// A result waiting in the output register stalls only the sequencer's final hand-over.
module binary_focal_loss_accumulator import bfl_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [PROB_BITS-1:0] pred_prob,
	input  logic [PROB_BITS-1:0] target_label,
	input  logic                 is_last,
	output logic                 empty,
	input  logic                 pop,
	output logic [MEAN_BITS-1:0] mean_loss,
	output logic                 saturated,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [15:0] gamma_q;
	logic [16:0] alpha_q;
	logic [14:0] eps_q;
	logic        cfg_wr;

	logic                   q_push, q_pop, q_nempty;
	item_t                  q_item, q_head;
	logic [QCOUNT_BITS-1:0] q_count;
	logic                   res_valid;
	result_t                res;
	logic                   out_valid_q;
	result_t                out_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			alpha_q <= ALPHA_RST;
			eps_q   <= EPS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GAMMA: gamma_q <= pwdata[15:0];
				REG_ALPHA: alpha_q <= pwdata[16:0];
				REG_EPS:   eps_q   <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAMMA: prdata = 32'(gamma_q);
			REG_ALPHA: prdata = 32'(alpha_q);
			REG_EPS:   prdata = 32'(eps_q);
			default:   prdata = '0;
		endcase
	end

	bfl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pred_prob    (pred_prob),
		.target_label (target_label),
		.is_last      (is_last),
		.alpha        (alpha_q),
		.eps          (eps_q),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	bfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.head      (q_head),
		.nempty    (q_nempty),
		.count     (q_count)
	);

	bfl_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gamma     (gamma_q),
		.head      (q_head),
		.q_nempty  (q_nempty),
		.q_pop     (q_pop),
		.out_free  (!out_valid_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign empty     = !out_valid_q;
	assign mean_loss = out_q.mean;
	assign saturated = out_q.sat;

`ifndef NO_ASSERTIONS
	a_res_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid_q)
		else $error("result handed over while output register occupied");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < QCOUNT_BITS'(QUEUE_DEPTH)))
		else $error("push into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("pop from an empty queue");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for binary_focal_loss_accumulator: predictor, driver, monitor.
// Depends on bfl_pkg and the RTL top level; needs no files or arguments.
`timescale 1ns / 100ps

module tb_top;
	import bfl_pkg::*;

	typedef struct {
		logic [PROB_BITS-1:0] p;
		logic [PROB_BITS-1:0] y;
		logic                 last;
	} elem_t;

	typedef struct {
		logic [MEAN_BITS-1:0] mean;
		logic                 sat;
	} loss_t;

	localparam logic [63:0] ONE64    = 64'd1 << FRAC_BITS;
	localparam logic [63:0] SUM_MAX  = (64'd1 << SUM_BITS) - 1;
	localparam logic [63:0] CNT_MAX  = (64'd1 << COUNT_BITS_DEF) - 1;
	localparam logic [63:0] MEAN_MAX = (64'd1 << MEAN_BITS) - 1;
	localparam logic [63:0] LN2_C    = 64'd2977044472;
	localparam int          SETTLE   = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [PROB_BITS-1:0] pred_prob;
	logic [PROB_BITS-1:0] target_label;
	logic                 is_last;
	logic                 empty;
	logic                 pop;
	logic [MEAN_BITS-1:0] mean_loss;
	logic                 saturated;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [3:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	binary_focal_loss_accumulator uut (.*);

	// Predictor state and register copies
	logic [15:0] gamma_r;
	logic [16:0] alpha_r;
	logic [14:0] eps_r;
	logic [63:0] run_sum;
	logic [63:0] run_cnt;
	logic        run_ovf;
	logic [63:0] roots [1:FRAC_BITS];

	elem_t pending_q [$];
	loss_t loss_q [$];
	int    fails;
	int    n_items;
	int    n_losses;

	function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// -log2(x/one) in Q.16 by repeated squaring of the mantissa
	function automatic logic [63:0] mlog2(input logic [63:0] x);
		int          k;
		logic [63:0] z;
		logic [63:0] f;
		k = 0;
		f = 0;
		for (int i = 0; i <= FRAC_BITS; i++) if (x[i]) k = i;
		z = x << (30 - k);
		for (int i = 0; i < FRAC_BITS; i++) begin
			z = (z * z) >> 30;
			f = f << 1;
			if (z >= (64'd1 << 31)) begin
				z = z >> 1;
				f = f | 1;
			end
		end
		return (64'(FRAC_BITS - k) << FRAC_BITS) - f;
	endfunction

	function automatic logic [63:0] pow2_neg(input logic [63:0] t);
		logic [63:0] n;
		logic [63:0] r;
		n = t >> FRAC_BITS;
		r = 64'd1 << 32;
		if (n >= 33) return 0;
		for (int i = 1; i <= FRAC_BITS; i++)
			if (t[FRAC_BITS - i]) r = (r * roots[i]) >> 32;
		r = r >> n;
		return r >> (32 - FRAC_BITS);
	endfunction

	function automatic logic [63:0] focus_pow(input logic [63:0] b, input logic [63:0] nl);
		logic [63:0] sq;
		if (gamma_r == GAMMA_ONE) return b;
		sq = (b * b) >> FRAC_BITS;
		if (gamma_r == GAMMA_TWO) return sq;
		if (gamma_r == GAMMA_THREE) return (sq * b) >> FRAC_BITS;
		return pow2_neg((64'(gamma_r) * nl) >> 12);
	endfunction

	function automatic logic [63:0] weighted_term(input logic [63:0] w, input logic [63:0] pb,
			input logic [63:0] lb);
		logic [63:0] lnm;
		logic [63:0] b;
		lnm = (mlog2(lb) * LN2_C) >> 32;
		b = (w * focus_pow(pb, mlog2(pb))) >> FRAC_BITS;
		return (b * lnm) >> FRAC_BITS;
	endfunction

	// Accumulate one element; queue the mean on the last one
	task automatic accumulate(input elem_t it);
		logic [63:0] p, y, e, a, w1, w2, term, mean;
		logic        clip;
		loss_t       res;
		p = 64'(it.p);
		y = 64'(it.y);
		e = (eps_r == '0) ? 64'd1 : 64'(eps_r);
		a = (64'(alpha_r) > ONE64) ? ONE64 : 64'(alpha_r);
		if (e > ONE64 / 2) e = ONE64 / 2;
		if (y > ONE64) y = ONE64;
		if (p < e) p = e;
		if (p > ONE64 - e) p = ONE64 - e;
		w1 = (a * y) >> FRAC_BITS;
		w2 = ((ONE64 - a) * (ONE64 - y)) >> FRAC_BITS;
		term = weighted_term(w1, ONE64 - p, p) + weighted_term(w2, p, ONE64 - p);
		if (run_sum > SUM_MAX - term) begin
			run_sum = SUM_MAX;
			run_ovf = 1;
		end else begin
			run_sum = run_sum + term;
		end
		if (run_cnt >= CNT_MAX) run_ovf = 1;
		else run_cnt = run_cnt + 1;
		n_items++;
		if (it.last) begin
			mean = run_cnt ? run_sum / run_cnt : 0;
			clip = mean > MEAN_MAX;
			if (clip) mean = MEAN_MAX;
			res.mean = mean[MEAN_BITS-1:0];
			res.sat = clip | run_ovf;
			loss_q.push_back(res);
			run_sum = 0;
			run_cnt = 0;
			run_ovf = 0;
		end
	endtask

	// Clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// Driver: bursts of transactions from the pending queue, random gaps between
	int    burst_left;
	int    gap_left;
	elem_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			pred_prob <= '0;
			target_label <= '0;
			is_last <= 0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (push && !full) accumulate(cur);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 0;
				end else if (pending_q.size() > 0) begin
					cur = pending_q.pop_front();
					push <= 1;
					pred_prob <= cur.p;
					target_label <= cur.y;
					is_last <= cur.last;
					if (burst_left == 0) burst_left = $urandom_range(1, 40);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
				end else begin
					push <= 0;
				end
			end
		end
	end

	// Monitor: check each result transaction and stall on a pattern of its own
	int hold_left;
	int mode_left;
	int pop_mode;

	always @(posedge clk or negedge arst_n) begin
		loss_t want;
		if (!arst_n) begin
			pop <= 0;
			hold_left = 0;
			mode_left = 0;
			pop_mode = 0;
		end else begin
			if (pop && !empty) begin
				if (loss_q.size() == 0) begin
					$error("result with none expected: mean_loss %0d", mean_loss);
					fails++;
				end else begin
					want = loss_q.pop_front();
					if (mean_loss !== want.mean) begin
						$error("mean_loss expected %0d actual %0d", want.mean, mean_loss);
						fails++;
					end
					if (saturated !== want.sat) begin
						$error("saturated expected %0d actual %0d", want.sat, saturated);
						fails++;
					end
				end
				n_losses++;
				// hold off once for a long stretch so the input backs up
				if (n_losses == 6) hold_left = 2000;
			end
			if (mode_left == 0) begin
				pop_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 0;
			end else begin
				case (pop_mode)
					0: pop <= 1;
					1: pop <= ($urandom_range(0, 3) != 0);
					default: pop <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Register write: setup then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_GAMMA: gamma_r = v[15:0];
			REG_ALPHA: alpha_r = v[16:0];
			default:   eps_r = v[14:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0 || push || loss_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic elem_t rand_elem(input logic last);
		elem_t  it;
		int     sel;
		logic [PROB_BITS-1:0] ends [4];
		ends = '{17'd0, 17'd1, 17'd65535, 17'd65536};
		sel = $urandom_range(0, 9);
		if (sel < 7) it.p = PROB_BITS'($urandom_range(0, 65536));
		else if (sel == 7) it.p = ends[$urandom_range(0, 3)];
		else if (sel == 8) it.p = PROB_BITS'($urandom_range(0, 131071));
		else it.p = PROB_BITS'(eps_r) + PROB_BITS'($urandom_range(0, 4));
		sel = $urandom_range(0, 9);
		if (sel < 7) it.y = $urandom_range(0, 1) ? ONE_Q : '0;
		else it.y = PROB_BITS'($urandom_range(0, 131071));
		it.last = last;
		return it;
	endfunction

	// Stimulus: directed tensors, then phases of random tensors under varied settings
	logic [31:0] cfg [10][3];
	logic [PROB_BITS-1:0] dp [6];
	logic [PROB_BITS-1:0] dy [4];
	elem_t it;
	int    len;
	int    left;

	initial begin
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		n_items = 0;
		n_losses = 0;
		gamma_r = GAMMA_RST;
		alpha_r = ALPHA_RST;
		eps_r = EPS_RST;
		run_sum = 0;
		run_cnt = 0;
		run_ovf = 0;
		roots[1] = sqrt_floor((64'd1 << 31) << 32);
		for (int i = 2; i <= FRAC_BITS; i++) roots[i] = sqrt_floor(roots[i-1] << 32);
		cfg = '{
			'{GAMMA_RST, ALPHA_RST, EPS_RST},
			'{GAMMA_ONE, 32'd65536, 32'd0},
			'{GAMMA_THREE, 32'd0, 32'd32767},
			'{32'd0, 32'd131071, 32'd16384},
			'{32'd65535, 32'd32768, 32'd1},
			'{32'd6144, 32'd20000, 32'd300},
			'{GAMMA_TWO, 32'd65535, 32'd32768},
			'{32'd2048, 32'd1, 32'd5},
			'{$urandom_range(0, 65535), $urandom_range(0, 131071), $urandom_range(0, 32767)},
			'{$urandom_range(0, 65535), $urandom_range(0, 65536), $urandom_range(0, 32767)}
		};
		dp = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65535};
		dy = '{17'd0, 17'd65536, 17'd131071, 17'd32768};
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: extremes of prediction against each target kind
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 4; j++) begin
				it.p = dp[i];
				it.y = dy[j];
				it.last = (j == 3) || (i == 0);
				pending_q.push_back(it);
			end
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph > 0)
				for (int r = 0; r < 3; r++) reg_write(2'(r), cfg[ph][r]);
			left = 160;
			while (left > 0) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60)
					: $urandom_range(1, 12);
				if (len > left) len = left;
				for (int k = 0; k < len; k++) pending_q.push_back(rand_elem(k == len - 1));
				left -= len;
			end
			// sender pauses here until every loss has arrived
			wait_idle();
		end

		$display("covered %0d elements and %0d losses over 10 register settings",
			n_items, n_losses);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
